### hw/rtl/rtcs_pkg.sv
// Shared types, codes and result builders for the RTC EEPROM commit sequencer.
package rtcs_pkg;

    localparam logic [2:0] REQ_UPDATE   = 3'd0;
    localparam logic [2:0] REQ_DONE     = 3'd1;
    localparam logic [2:0] REQ_INTR     = 3'd2;
    localparam logic [2:0] REQ_PERIODIC = 3'd3;
    localparam logic [2:0] REQ_INIT     = 3'd4;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_DELAY = 3'd3;
    localparam logic [2:0] ACT_REPLY = 3'd4;
    localparam logic [2:0] ACT_ALARM = 3'd5;

    localparam logic [1:0] RST_OK   = 2'd0;
    localparam logic [1:0] RST_BUSY = 2'd1;
    localparam logic [1:0] RST_FAIL = 2'd2;

    localparam logic [7:0] STATUS_ADDR = 8'd14;
    localparam logic [7:0] CTRL1_ADDR  = 8'd15;
    localparam logic [7:0] BACKUP_ADDR = 8'd55;
    localparam logic [7:0] EECMD_ADDR  = 8'd39;

    localparam logic [1:0] ONE_BYTE   = 2'd1;
    localparam logic [1:0] CNT_TRIPLE = 2'd3;

    localparam logic [7:0] M_EEBUSY = 8'h80;
    localparam logic [7:0] M_UF     = 8'h10;
    localparam logic [7:0] M_EERD   = 8'h08;
    localparam logic [7:0] M_USEL   = 8'h10;
    localparam logic [7:0] M_UIE    = 8'h20;
    localparam logic [7:0] M_TCE    = 8'h20;
    localparam logic [7:0] M_FEDE   = 8'h10;

    localparam logic [7:0] CMD_FIRST  = 8'h00;
    localparam logic [7:0] CMD_UPDATE = 8'h11;

    localparam logic [7:0] MODE_OFF    = 8'd0;
    localparam logic [7:0] MODE_MINUTE = 8'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic       done_ok;
        logic [7:0] read_byte0;
        logic [7:0] read_byte1;
        logic [7:0] read_byte2;
        logic [7:0] requester;
        logic [7:0] periodic_mode;
        logic [7:0] periodic_dest;
        logic       int_pin_low;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] reg_addr;
        logic [1:0] byte_count;
        logic [7:0] wdata0;
        logic [7:0] wdata1;
        logic [7:0] wdata2;
        logic [7:0] dest;
        logic [1:0] reply_status;
        logic       irq_enable;
        logic       last;
    } res_t;

    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] cnt;
    } pair_t;

    function automatic res_t mk_res(input logic [2:0] action, input logic [7:0] addr,
                                    input logic [1:0] cnt, input logic [7:0] w0,
                                    input logic [7:0] w1, input logic [7:0] w2,
                                    input logic [7:0] dst, input logic [1:0] st,
                                    input logic irq);
        res_t r;
        r.action       = action;
        r.reg_addr     = addr;
        r.byte_count   = cnt;
        r.wdata0       = w0;
        r.wdata1       = w1;
        r.wdata2       = w2;
        r.dest         = dst;
        r.reply_status = st;
        r.irq_enable   = irq;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic res_t bus_read(input logic [7:0] addr, input logic [1:0] cnt);
        return mk_res(ACT_READ, addr, cnt, 8'd0, 8'd0, 8'd0, 8'd0, RST_OK, 1'b0);
    endfunction

    function automatic res_t bus_write1(input logic [7:0] addr, input logic [7:0] b);
        return mk_res(ACT_WRITE, addr, ONE_BYTE, b, 8'd0, 8'd0, 8'd0, RST_OK, 1'b0);
    endfunction

    function automatic res_t start_delay();
        return mk_res(ACT_DELAY, 8'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, RST_OK, 1'b0);
    endfunction

    function automatic res_t send_reply(input logic [7:0] dst, input logic [1:0] st);
        return mk_res(ACT_REPLY, 8'd0, 2'd0, 8'd0, 8'd0, 8'd0, dst, st, 1'b0);
    endfunction

    function automatic res_t serve_intr(input logic [7:0] alarm_dest);
        if (alarm_dest != 8'd0) begin
            return mk_res(ACT_ALARM, 8'd0, 2'd0, 8'd0, 8'd0, 8'd0, alarm_dest, RST_OK, 1'b1);
        end
        return mk_res(ACT_NONE, 8'd0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, RST_OK, 1'b1);
    endfunction

endpackage

### hw/rtl/rtcs_seq.sv
// Sequencer state and next-state logic producing up to two results per word.
module rtcs_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  rtcs_pkg::item_t    item,
    output rtcs_pkg::pair_t    pair
);

    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_WAIT        = 4'd1;
    localparam logic [3:0] S_RD_BUSY     = 4'd2;
    localparam logic [3:0] S_RD_BACKUP   = 4'd3;
    localparam logic [3:0] S_RD_CTL1     = 4'd4;
    localparam logic [3:0] S_WR_EERD     = 4'd5;
    localparam logic [3:0] S_WR_FIRST    = 4'd6;
    localparam logic [3:0] S_WR_BACKUP   = 4'd7;
    localparam logic [3:0] S_WR_UPDATE   = 4'd8;
    localparam logic [3:0] S_UPD_DELAY   = 4'd9;
    localparam logic [3:0] S_RD_PERIODIC = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       pending_reg, pending_next;
    logic       per_on_reg, per_on_next;
    logic       per_min_reg, per_min_next;
    logic [7:0] ctl1_reg, ctl1_next;
    logic [7:0] bkup_reg, bkup_next;
    logic [7:0] reply_dest_reg, reply_dest_next;
    logic [7:0] alarm_dest_reg, alarm_dest_next;

    logic [3:0]      st_eff;
    logic            busy;
    logic            pv;
    logic            sv;
    rtcs_pkg::res_t  pres;
    rtcs_pkg::res_t  sres;
    logic [7:0]      nb;

    always_comb begin
        st_eff          = (state_reg > S_RD_PERIODIC) ? S_IDLE : state_reg;
        busy            = (st_eff != S_IDLE);
        state_next      = st_eff;
        pending_next    = pending_reg;
        per_on_next     = per_on_reg;
        per_min_next    = per_min_reg;
        ctl1_next       = ctl1_reg;
        bkup_next       = bkup_reg;
        reply_dest_next = reply_dest_reg;
        alarm_dest_next = alarm_dest_reg;
        pv              = 1'b0;
        sv              = 1'b0;
        pres            = rtcs_pkg::start_delay();
        nb              = 8'd0;
        unique case (item.req_type)
            rtcs_pkg::REQ_UPDATE: begin
                pv = 1'b1;
                if (!busy) begin
                    reply_dest_next = item.requester;
                    state_next      = S_RD_BUSY;
                    pres = rtcs_pkg::bus_read(rtcs_pkg::STATUS_ADDR, rtcs_pkg::CNT_TRIPLE);
                end else begin
                    pres = rtcs_pkg::send_reply(item.requester, rtcs_pkg::RST_BUSY);
                end
            end
            rtcs_pkg::REQ_DONE: begin
                pv = 1'b1;
                if (busy && item.done_ok) begin
                    unique case (st_eff)
                        S_WAIT: begin
                            state_next = S_RD_BUSY;
                            pres = rtcs_pkg::bus_read(rtcs_pkg::STATUS_ADDR,
                                                      rtcs_pkg::CNT_TRIPLE);
                        end
                        S_RD_BUSY: begin
                            ctl1_next = item.read_byte1;
                            if ((item.read_byte0 & rtcs_pkg::M_EEBUSY) != 8'd0) begin
                                state_next = S_WAIT;
                                pres       = rtcs_pkg::start_delay();
                            end else begin
                                state_next = S_RD_BACKUP;
                                pres = rtcs_pkg::bus_read(rtcs_pkg::BACKUP_ADDR,
                                                          rtcs_pkg::ONE_BYTE);
                            end
                        end
                        S_RD_BACKUP: begin
                            bkup_next  = item.read_byte0;
                            state_next = S_RD_CTL1;
                            pres = rtcs_pkg::bus_read(rtcs_pkg::CTRL1_ADDR, rtcs_pkg::ONE_BYTE);
                        end
                        S_RD_CTL1: begin
                            nb         = item.read_byte0 | rtcs_pkg::M_EERD;
                            ctl1_next  = nb;
                            state_next = S_WR_EERD;
                            pres       = rtcs_pkg::bus_write1(rtcs_pkg::CTRL1_ADDR, nb);
                        end
                        S_WR_EERD: begin
                            if ((bkup_reg & rtcs_pkg::M_TCE) != 8'd0
                                    || (bkup_reg & rtcs_pkg::M_FEDE) == 8'd0) begin
                                state_next = S_WR_FIRST;
                            end else begin
                                state_next = S_WR_BACKUP;
                            end
                            pres = rtcs_pkg::bus_write1(rtcs_pkg::EECMD_ADDR,
                                                        rtcs_pkg::CMD_FIRST);
                        end
                        S_WR_FIRST: begin
                            nb         = (bkup_reg & ~rtcs_pkg::M_TCE) | rtcs_pkg::M_FEDE;
                            bkup_next  = nb;
                            state_next = S_WR_BACKUP;
                            pres       = rtcs_pkg::bus_write1(rtcs_pkg::BACKUP_ADDR, nb);
                        end
                        S_WR_BACKUP: begin
                            state_next = S_WR_UPDATE;
                            pres = rtcs_pkg::bus_write1(rtcs_pkg::EECMD_ADDR,
                                                        rtcs_pkg::CMD_UPDATE);
                        end
                        S_WR_UPDATE: begin
                            state_next = S_UPD_DELAY;
                            pres       = rtcs_pkg::start_delay();
                        end
                        S_UPD_DELAY: begin
                            nb         = ctl1_reg & ~rtcs_pkg::M_EERD;
                            ctl1_next  = nb;
                            state_next = S_IDLE;
                            pres       = rtcs_pkg::bus_write1(rtcs_pkg::CTRL1_ADDR, nb);
                        end
                        S_RD_PERIODIC: begin
                            state_next = S_IDLE;
                            pres = rtcs_pkg::mk_res(rtcs_pkg::ACT_WRITE, rtcs_pkg::STATUS_ADDR,
                                rtcs_pkg::CNT_TRIPLE,
                                item.read_byte0 & ~rtcs_pkg::M_UF,
                                per_min_reg ? (item.read_byte1 | rtcs_pkg::M_USEL)
                                            : (item.read_byte1 & ~rtcs_pkg::M_USEL),
                                per_on_reg ? (item.read_byte2 | rtcs_pkg::M_UIE)
                                           : (item.read_byte2 & ~rtcs_pkg::M_UIE),
                                8'd0, rtcs_pkg::RST_OK, 1'b1);
                        end
                        default: begin
                            pv         = 1'b0;
                            state_next = S_IDLE;
                        end
                    endcase
                end else begin
                    state_next      = S_IDLE;
                    pres = rtcs_pkg::send_reply(reply_dest_reg,
                        item.done_ok ? rtcs_pkg::RST_OK : rtcs_pkg::RST_FAIL);
                    reply_dest_next = 8'd0;
                end
                if (state_next == S_IDLE && pending_reg) begin
                    sv = 1'b1;
                end
            end
            rtcs_pkg::REQ_INTR: begin
                if (busy) begin
                    pending_next = 1'b1;
                end else begin
                    sv = 1'b1;
                end
            end
            rtcs_pkg::REQ_PERIODIC: begin
                pv = 1'b1;
                if (busy) begin
                    pres = rtcs_pkg::send_reply(item.requester, rtcs_pkg::RST_BUSY);
                end else begin
                    per_on_next     = (item.periodic_mode != rtcs_pkg::MODE_OFF);
                    per_min_next    = (item.periodic_mode == rtcs_pkg::MODE_MINUTE);
                    alarm_dest_next = item.periodic_dest;
                    reply_dest_next = item.requester;
                    state_next      = S_RD_PERIODIC;
                    pres = rtcs_pkg::bus_read(rtcs_pkg::STATUS_ADDR, rtcs_pkg::CNT_TRIPLE);
                end
            end
            rtcs_pkg::REQ_INIT: begin
                pv   = 1'b1;
                pres = rtcs_pkg::send_reply(item.requester, rtcs_pkg::RST_OK);
                sv   = item.int_pin_low;
            end
            default: begin
                pv = 1'b0;
            end
        endcase
        if (sv) begin
            pending_next = 1'b0;
        end
        sres = rtcs_pkg::serve_intr(alarm_dest_reg);
    end

    always_comb begin
        pair.r0 = pv ? pres : sres;
        pair.r1 = sres;
        pair.cnt = {1'b0, pv} + {1'b0, sv};
        pair.r0.last = !(pv && sv);
        pair.r1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pending_reg    <= 1'b0;
            per_on_reg     <= 1'b0;
            per_min_reg    <= 1'b0;
            ctl1_reg       <= 8'd0;
            bkup_reg       <= 8'd0;
            reply_dest_reg <= 8'd0;
            alarm_dest_reg <= 8'd0;
        end else if (fire) begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            per_on_reg     <= per_on_next;
            per_min_reg    <= per_min_next;
            ctl1_reg       <= ctl1_next;
            bkup_reg       <= bkup_next;
            reply_dest_reg <= reply_dest_next;
            alarm_dest_reg <= alarm_dest_next;
        end
    end

endmodule

### hw/rtl/rtcs_out.sv
// Result register holding one or two results and handing them out in order.
module rtcs_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  rtcs_pkg::pair_t   pair,
    output logic              free,
    input  logic              m_tready,
    output logic              m_tvalid,
    output rtcs_pkg::res_t    res
);

    rtcs_pkg::pair_t pair_reg;
    logic            valid_reg;
    logic            idx_reg;
    logic            take;
    logic            last_beat;

    assign take      = valid_reg && m_tready;
    assign last_beat = idx_reg || (pair_reg.cnt == 2'd1);
    assign free      = !valid_reg || (take && last_beat);
    assign m_tvalid  = valid_reg;
    assign res       = idx_reg ? pair_reg.r1 : pair_reg.r0;

    always_ff @(posedge aclk) begin
        if (load && free && pair.cnt != 2'd0) begin
            pair_reg <= pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else if (load && free && pair.cnt != 2'd0) begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end else if (take && last_beat) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else if (take) begin
            idx_reg   <= 1'b1;
        end
    end

endmodule

### hw/rtl/rtc_eeprom_commit_sequencer_core.sv
// Top level of the RTC EEPROM commit sequencer: input register, sequencer, result register.
//
//  port group  dir  tdata / tuser               tlast
//  s_*         in   request word, req_type      -
//  m_*         out  result word, action         last result of a request
//
//  A request word is registered, decoded combinationally and its results written to
//  the result register; one word per cycle while each word yields at most one result.
//  A word with two results holds the result register for two output beats.
//  Synchronous active-low reset clears the sequencer to idle and empties both registers.
//  A stalled m_tready holds the result register; s_tready drops only when both are full.
module rtc_eeprom_commit_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // done_ok[0], read_byte0[8:1], read_byte1[16:9], read_byte2[24:17],
    // requester[32:25], periodic_mode[40:33], periodic_dest[48:41], int_pin_low[49]
    input  logic [55:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // reg_addr[7:0], byte_count[9:8], wdata0[17:10], wdata1[25:18], wdata2[33:26],
    // dest[41:34], reply_status[43:42], irq_enable[44]
    output logic [47:0] m_tdata,
    // action[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    rtcs_pkg::item_t item_reg;
    logic            in_v_reg;
    logic            fire;
    logic            free;
    rtcs_pkg::pair_t pair;
    rtcs_pkg::res_t  res;

    assign fire     = in_v_reg && (pair.cnt == 2'd0 || free);
    assign s_tready = !in_v_reg || fire;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.req_type      <= s_tuser;
            item_reg.done_ok       <= s_tdata[0];
            item_reg.read_byte0    <= s_tdata[8:1];
            item_reg.read_byte1    <= s_tdata[16:9];
            item_reg.read_byte2    <= s_tdata[24:17];
            item_reg.requester     <= s_tdata[32:25];
            item_reg.periodic_mode <= s_tdata[40:33];
            item_reg.periodic_dest <= s_tdata[48:41];
            item_reg.int_pin_low   <= s_tdata[49];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    rtcs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .pair    (pair)
    );

    rtcs_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .pair     (pair),
        .free     (free),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res      (res)
    );

    assign m_tdata = {3'd0, res.irq_enable, res.reply_status, res.dest, res.wdata2,
                      res.wdata1, res.wdata0, res.byte_count, res.reg_addr};
    assign m_tuser = res.action;
    assign m_tlast = res.last;

endmodule
